// ===== rtl/size_class_slab_allocator_core_assert.svh =====
// ----------------------------------------------------------------------------
// size_class_slab_allocator_core_assert.svh
// assertion macros for the slab allocator, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef SIZE_CLASS_SLAB_ALLOCATOR_CORE_ASSERT_SVH
`define SIZE_CLASS_SLAB_ALLOCATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SCSA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SCSA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SCSA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)

`define SCSA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/scsa_pkg.sv =====
// ----------------------------------------------------------------------------
// scsa_pkg
// shared types and codes of the size-class slab allocator
// ----------------------------------------------------------------------------
package scsa_pkg;

    // widest class index that any configuration can need (up to 16 classes)
    localparam int CLS_IDX_W = 4;

    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CLASS_COUNT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SIZE_LOG2   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLABS_PER_BLOCK = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_BLOCKS      = 2'd3;

    // configuration reset values
    localparam logic [3:0]  RST_CLASS_COUNT     = 4'd8;
    localparam logic [4:0]  RST_MIN_SIZE_LOG2   = 5'd2;
    localparam logic [12:0] RST_SLABS_PER_BLOCK = 13'd100;
    localparam logic [12:0] RST_MAX_BLOCKS      = 13'd0;

    // smallest element size is 4 bytes
    localparam logic [4:0] MIN_LOG2_FLOOR = 5'd2;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EXHAUSTED = 2'd1,
        STAT_TOO_BIG   = 2'd2,
        STAT_IGNORED   = 2'd3
    } scsa_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_POP
    } scsa_state_t;

    // class lookup result
    typedef struct packed {
        logic                 hit;
        logic [CLS_IDX_W-1:0] idx;
    } scsa_sel_t;

endpackage

// ===== rtl/scsa_class_sel.sv =====
// ----------------------------------------------------------------------------
// scsa_class_sel
// picks the first size class in use whose element size covers the request
// ----------------------------------------------------------------------------
module scsa_class_sel #(
    parameter int NUM_CLASSES = 8
) (
    input  logic [23:0]         req_size,
    input  logic [3:0]          class_count,
    input  logic [4:0]          min_size_log2,
    output scsa_pkg::scsa_sel_t sel
);

    logic [4:0] n_cls;
    logic [4:0] lg;

    always_comb
    begin
        if (class_count == 4'd0)
        begin
            n_cls = 5'd1;
        end
        else if (5'(class_count) > 5'(NUM_CLASSES))
        begin
            n_cls = 5'(NUM_CLASSES);
        end
        else
        begin
            n_cls = 5'(class_count);
        end
        lg = (min_size_log2 < scsa_pkg::MIN_LOG2_FLOOR) ? scsa_pkg::MIN_LOG2_FLOOR
                                                        : min_size_log2;
    end

    // scan from the top so the lowest matching class wins
    always_comb
    begin
        logic [5:0]  shamt;
        logic [32:0] limit;
        sel.hit = 1'b0;
        sel.idx = '0;
        for (int i = NUM_CLASSES - 1; i >= 0; i--)
        begin
            shamt = 6'(lg) + 6'(i);
            limit = 33'd1 << shamt;
            if ((5'(i) < n_cls) && (33'(req_size) <= limit))
            begin
                sel.hit = 1'b1;
                sel.idx = scsa_pkg::CLS_IDX_W'(i);
            end
        end
    end

endmodule

// ===== rtl/size_class_slab_allocator_core.sv =====
// ----------------------------------------------------------------------------
// size_class_slab_allocator_core
// slab allocator with power-of-two size classes, per-class free lists in a
// link memory and a block/index bump cursor per class
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  request   start / busy         kind, req_size, slot_handle, handle_present
//  result    done (strobe)        status, class_id, granted_slot
//  config    cfg_we               cfg_index, cfg_data
//
//  a beat goes from acceptance through ST_EXEC to done; an allocate popping the
//  free list also passes ST_POP: the link of the popped slot comes out of the
//  link memory in the cycle after the head is read. busy is high from acceptance
//  until the cycle done is shown, so a new beat can be taken while done is high.
//  reset clears heads to empty and cursors to zero at once; the link memory
//  needs no clearing. done cannot be held off by the receiver.
// ----------------------------------------------------------------------------
`include "size_class_slab_allocator_core_assert.svh"

module size_class_slab_allocator_core #(
    parameter int NUM_CLASSES     = 8,
    parameter int SLOTS_PER_CLASS = 4096
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        start,
    output logic        busy,
    input  logic        kind,
    input  logic [23:0] req_size,
    input  logic [11:0] slot_handle,
    input  logic        handle_present,

    input  logic                               cfg_we,
    input  logic [scsa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [scsa_pkg::CFG_DATA_W-1:0]    cfg_data,

    output logic        done,
    output logic [1:0]  status,
    output logic [2:0]  class_id,
    output logic [11:0] granted_slot
);

    localparam int CW        = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int SLW       = $clog2(SLOTS_PER_CLASS);
    localparam int SW        = $clog2(SLOTS_PER_CLASS + 1);
    localparam int MEM_DEPTH = NUM_CLASSES << SLW;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int PW        = SLW + 15;
    localparam logic [SW-1:0] EMPTY = SW'(SLOTS_PER_CLASS);

    // configuration
    logic [3:0]  cc_reg;
    logic [4:0]  msl_reg;
    logic [12:0] spb_reg;
    logic [12:0] mb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc_reg  <= scsa_pkg::RST_CLASS_COUNT;
            msl_reg <= scsa_pkg::RST_MIN_SIZE_LOG2;
            spb_reg <= scsa_pkg::RST_SLABS_PER_BLOCK;
            mb_reg  <= scsa_pkg::RST_MAX_BLOCKS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                scsa_pkg::REG_CLASS_COUNT:     cc_reg  <= cfg_data[3:0];
                scsa_pkg::REG_MIN_SIZE_LOG2:   msl_reg <= cfg_data[4:0];
                scsa_pkg::REG_SLABS_PER_BLOCK: spb_reg <= cfg_data[12:0];
                scsa_pkg::REG_MAX_BLOCKS:      mb_reg  <= cfg_data[12:0];
            endcase
        end
    end

    // class lookup on the incoming beat
    scsa_pkg::scsa_sel_t sel;

    scsa_class_sel #(
        .NUM_CLASSES (NUM_CLASSES)
    ) u_class_sel (
        .req_size      (req_size),
        .class_count   (cc_reg),
        .min_size_log2 (msl_reg),
        .sel           (sel)
    );

    scsa_pkg::scsa_state_t state_reg, state_next;

    logic accept;
    assign accept = start && (state_reg == scsa_pkg::ST_IDLE);
    assign busy   = (state_reg != scsa_pkg::ST_IDLE);

    // captured request
    logic          kind_reg;
    logic [11:0]   handle_reg;
    logic          present_reg;
    logic          hit_reg;
    logic [CW-1:0] cls_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg    <= kind;
            handle_reg  <= slot_handle;
            present_reg <= handle_present;
            hit_reg     <= sel.hit;
            cls_reg     <= CW'(sel.idx);
        end
    end

    // per-class state
    logic [SW-1:0]  head_reg [NUM_CLASSES];
    logic [SW-1:0]  head_next [NUM_CLASSES];
    logic [SLW-1:0] blk_reg  [NUM_CLASSES];
    logic [SLW-1:0] blk_next [NUM_CLASSES];
    logic [12:0]    idx_reg  [NUM_CLASSES];
    logic [12:0]    idx_next [NUM_CLASSES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= scsa_pkg::ST_IDLE;
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                head_reg[c] <= EMPTY;
                blk_reg[c]  <= '0;
                idx_reg[c]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            blk_reg   <= blk_next;
            idx_reg   <= idx_next;
        end
    end

    // link memory, one entry per slot of each class
    logic [SW-1:0] link_mem [MEM_DEPTH];
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic [SW-1:0] mem_wdata;
    logic [SW-1:0] link_rd_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            link_rd_reg <= link_mem[mem_raddr];
        end
    end

    // bump cursor arithmetic for the captured class
    logic [SW-1:0]  head_cur;
    logic           head_has;
    logic [12:0]    spb_eff;
    logic [SLW-1:0] blk_cur;
    logic [12:0]    idx_cur;
    logic           blk_full;
    logic [SLW:0]   blk_eff;
    logic [12:0]    idx_eff;
    logic           limit_hit;
    logic [PW-1:0]  bump_slot;
    logic           bump_ok;
    logic           handle_ok;
    logic [SW-1:0]  handle_slot;

    always_comb
    begin
        head_cur  = head_reg[cls_reg];
        head_has  = (head_cur < EMPTY);
        spb_eff   = (spb_reg == 13'd0) ? 13'd1 : spb_reg;
        blk_cur   = blk_reg[cls_reg];
        idx_cur   = idx_reg[cls_reg];
        // a cursor at or past the block size counts as a full block
        blk_full  = (idx_cur >= spb_eff);
        blk_eff   = blk_full ? ((SLW + 1)'(blk_cur) + (SLW + 1)'(1)) : (SLW + 1)'(blk_cur);
        idx_eff   = blk_full ? 13'd0 : idx_cur;
        limit_hit = blk_full && (mb_reg != 13'd0)
                    && ((PW'(blk_cur) + PW'(1)) >= PW'(mb_reg));
        bump_slot = PW'(blk_eff) * PW'(spb_eff) + PW'(idx_eff);
        bump_ok   = !limit_hit && (bump_slot < PW'(SLOTS_PER_CLASS));
        handle_ok = (32'(handle_reg) < 32'(SLOTS_PER_CLASS));
        handle_slot = SW'(handle_reg);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            scsa_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = scsa_pkg::ST_EXEC;
                end
            end
            scsa_pkg::ST_EXEC:
            begin
                // handle_present plays no part in an allocate
                if (hit_reg && (kind_reg == scsa_pkg::KIND_ALLOC) && head_has)
                begin
                    state_next = scsa_pkg::ST_POP;
                end
                else
                begin
                    state_next = scsa_pkg::ST_IDLE;
                end
            end
            scsa_pkg::ST_POP:
            begin
                state_next = scsa_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = scsa_pkg::ST_IDLE;
            end
        endcase
    end

    // results and state updates
    logic                   res_load;
    scsa_pkg::scsa_status_t res_status_next;
    logic [CW-1:0]          res_cls_next;
    logic [SW-1:0]          res_slot_next;

    always_comb
    begin
        head_next       = head_reg;
        blk_next        = blk_reg;
        idx_next        = idx_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = AW'({cls_reg, handle_slot[SLW-1:0]});
        mem_wdata       = head_cur;
        mem_raddr       = AW'({cls_reg, head_cur[SLW-1:0]});
        res_load        = 1'b0;
        res_status_next = scsa_pkg::STAT_OK;
        res_cls_next    = '0;
        res_slot_next   = '0;
        unique case (state_reg)
            scsa_pkg::ST_IDLE:
            begin
            end
            scsa_pkg::ST_EXEC:
            begin
                if ((kind_reg == scsa_pkg::KIND_FREE) && !present_reg)
                begin
                    res_load        = 1'b1;
                    res_status_next = scsa_pkg::STAT_IGNORED;
                end
                else if (!hit_reg)
                begin
                    res_load        = 1'b1;
                    res_status_next = scsa_pkg::STAT_TOO_BIG;
                end
                else if (kind_reg == scsa_pkg::KIND_FREE)
                begin
                    res_load = 1'b1;
                    if (handle_ok)
                    begin
                        // push: freed slot links to the old head and becomes head
                        mem_we             = 1'b1;
                        head_next[cls_reg] = handle_slot;
                        res_cls_next       = cls_reg;
                    end
                    else
                    begin
                        res_status_next = scsa_pkg::STAT_IGNORED;
                    end
                end
                else if (head_has)
                begin
                    mem_re = 1'b1;
                end
                else
                begin
                    res_load     = 1'b1;
                    res_cls_next = cls_reg;
                    if (bump_ok)
                    begin
                        blk_next[cls_reg] = SLW'(blk_eff);
                        idx_next[cls_reg] = idx_eff + 13'd1;
                        res_slot_next     = SW'(bump_slot);
                    end
                    else
                    begin
                        res_status_next = scsa_pkg::STAT_EXHAUSTED;
                    end
                end
            end
            scsa_pkg::ST_POP:
            begin
                // a corrupt link leaves the list empty
                head_next[cls_reg] = (link_rd_reg < EMPTY) ? link_rd_reg : EMPTY;
                res_load           = 1'b1;
                res_cls_next       = cls_reg;
                res_slot_next      = head_cur;
            end
            default:
            begin
            end
        endcase
    end

    // result registers
    logic                   done_reg;
    scsa_pkg::scsa_status_t res_status_reg;
    logic [CW-1:0]          res_cls_reg;
    logic [SW-1:0]          res_slot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= res_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_status_reg <= res_status_next;
            res_cls_reg    <= res_cls_next;
            res_slot_reg   <= res_slot_next;
        end
    end

    assign done         = done_reg;
    assign status       = res_status_reg;
    assign class_id     = 3'(res_cls_reg);
    assign granted_slot = 12'(res_slot_reg);

    `SCSA_ASSERT_NXT(a_accept_goes_busy, clk, rst_n, start && !busy, busy, "beat taken, not busy")
    `SCSA_ASSERT_IMP(a_done_after_work, clk, rst_n, done, $past(busy), "strobe without work")
    `SCSA_ASSERT_IMP(a_slot_only_on_ok, clk, rst_n,
        done && (status != scsa_pkg::STAT_OK), granted_slot == 12'd0, "slot on failed beat")
    `SCSA_ASSERT_IMP(a_head_in_range, clk, rst_n,
        busy, head_cur <= EMPTY, "free list head out of range")

endmodule
